// ----- hw/rtl/dfr_pkg.sv -----
// Shared types and constants for the digit frame receiver.
// No dependencies.
package dfr_pkg;

  localparam int DIGIT_SLOTS_DEF = 4;
  localparam int OUT_DIGITS      = 4;
  localparam int CTR_W           = 32;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;

  localparam logic [7:0] HEAD_BYTE_RST   = 8'd18;
  localparam logic [7:0] TAIL_BYTE_RST   = 8'd91;
  localparam logic [3:0] DIGIT_LIMIT_RST = 4'd8;

  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_HEAD_BYTE   = 2'd0;
  localparam reg_idx_t REG_TAIL_BYTE   = 2'd1;
  localparam reg_idx_t REG_DIGIT_LIMIT = 2'd2;

  typedef struct packed {
    logic                        frame_done;
    logic                        ack_result;
    logic                        pending;
    logic [2:0]                  digit_count;
    logic [OUT_DIGITS-1:0][3:0]  digits;
    logic [CTR_W-1:0]            frames_received;
    logic [CTR_W-1:0]            errors_seen;
  } result_t;

endpackage

// ----- hw/rtl/digit_frame_receiver.sv -----
// Digit frame receiver: parses head/count/digits/check/tail byte frames.
// Depends on dfr_pkg.
// An accepted item's result is registered in the output register or the skid.
// Throughput: 1 item per cycle while in_stall is low; a two-entry output
// buffer (register plus skid) takes one more item after the output stalls.
// Reset (rst, synchronous): parser hunting for a head, counters, pending flag
// and published digits cleared, registers back to 18 / 91 / 8.
module digit_frame_receiver #(
  parameter int DIGIT_SLOTS = dfr_pkg::DIGIT_SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       command,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       frame_done,
  output logic                       ack_result,
  output logic                       pending,
  output logic [2:0]                 digit_count,
  output logic [3:0]                 digit_0,
  output logic [3:0]                 digit_1,
  output logic [3:0]                 digit_2,
  output logic [3:0]                 digit_3,
  output logic [dfr_pkg::CTR_W-1:0]  frames_received,
  output logic [dfr_pkg::CTR_W-1:0]  errors_seen,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dfr_pkg::ADDR_W-1:0] paddr,
  input  logic [dfr_pkg::DATA_W-1:0] pwdata,
  output logic [dfr_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import dfr_pkg::*;

  localparam int CNT_W = $clog2(DIGIT_SLOTS + 1);
  localparam logic [CNT_W-1:0] LAST_SLOT  = CNT_W'(DIGIT_SLOTS - 1);
  localparam logic [7:0]       BYTE_SLOTS = 8'(DIGIT_SLOTS);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_COUNT,
    PH_DIGITS,
    PH_CHECK,
    PH_TAIL
  } phase_t;

  // config registers
  logic [7:0] head_byte;
  logic [7:0] tail_byte;
  logic [3:0] digit_limit;
  reg_idx_t   reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte   <= HEAD_BYTE_RST;
      tail_byte   <= TAIL_BYTE_RST;
      digit_limit <= DIGIT_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_HEAD_BYTE:   head_byte   <= pwdata[7:0];
        REG_TAIL_BYTE:   tail_byte   <= pwdata[7:0];
        REG_DIGIT_LIMIT: digit_limit <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEAD_BYTE:   prdata = DATA_W'(head_byte);
      REG_TAIL_BYTE:   prdata = DATA_W'(tail_byte);
      REG_DIGIT_LIMIT: prdata = DATA_W'(digit_limit);
      default:         prdata = '0;
    endcase
  end

  // parser state
  phase_t           phase, phase_next;
  logic [CNT_W-1:0] slot, slot_next;
  logic [7:0]       rxor, rxor_next;
  logic [CNT_W-1:0] fcnt, fcnt_next;
  logic [3:0]       fdig [DIGIT_SLOTS];
  logic [3:0]       fdig_next [DIGIT_SLOTS];
  logic [CNT_W-1:0] scnt, scnt_next;
  logic [3:0]       sdig [DIGIT_SLOTS];
  logic [3:0]       sdig_next [DIGIT_SLOTS];
  logic [CTR_W-1:0] good, good_next;
  logic [CTR_W-1:0] bad, bad_next;
  logic             pend, pend_next;
  logic             done, ack, err;
  logic             slot_used, digit_ok;

  assign slot_used = slot < fcnt;
  assign digit_ok  = slot_used ? (rx_byte != 8'd0 && rx_byte <= {4'd0, digit_limit})
                               : (rx_byte == 8'd0);

  always_comb begin
    phase_next = phase;
    slot_next  = slot;
    rxor_next  = rxor;
    fcnt_next  = fcnt;
    fdig_next  = fdig;
    scnt_next  = scnt;
    sdig_next  = sdig;
    good_next  = good;
    bad_next   = bad;
    pend_next  = pend;
    done       = 1'b0;
    ack        = 1'b0;
    err        = 1'b0;
    if (command) begin
      ack       = pend;
      pend_next = 1'b0;
    end else begin
      unique case (phase)
        PH_HUNT: begin
          if (rx_byte == head_byte && !pend) phase_next = PH_COUNT;
        end
        PH_COUNT: begin
          if (rx_byte <= BYTE_SLOTS) begin
            fcnt_next  = rx_byte[CNT_W-1:0];
            rxor_next  = rx_byte;
            slot_next  = '0;
            phase_next = PH_DIGITS;
          end else begin
            err = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (digit_ok) begin
            for (int k = 0; k < DIGIT_SLOTS; k++) begin
              if (slot == CNT_W'(k)) fdig_next[k] = rx_byte[3:0];
            end
            slot_next = slot + CNT_W'(1);
            rxor_next = rxor ^ rx_byte;
            if (slot == LAST_SLOT) phase_next = PH_CHECK;
          end else begin
            err = 1'b1;
          end
        end
        PH_CHECK: begin
          if (rx_byte == rxor) phase_next = PH_TAIL;
          else err = 1'b1;
        end
        PH_TAIL: begin
          if (rx_byte == tail_byte) begin
            scnt_next = fcnt;
            for (int k = 0; k < DIGIT_SLOTS; k++) begin
              if (CNT_W'(k) < fcnt) sdig_next[k] = fdig[k];
            end
            good_next  = good + CTR_W'(1);
            pend_next  = 1'b1;
            phase_next = PH_HUNT;
            done       = 1'b1;
          end else begin
            err = 1'b1;
          end
        end
        default: phase_next = PH_HUNT;
      endcase
      if (err) begin
        bad_next   = bad + CTR_W'(1);
        phase_next = (rx_byte == head_byte) ? PH_COUNT : PH_HUNT;
      end
    end
  end

  // published digits, positions past the slot count read 0
  logic [OUT_DIGITS-1:0][3:0] sdig_out;
  for (genvar g = 0; g < OUT_DIGITS; g++) begin : g_out
    if (g < DIGIT_SLOTS) begin : g_used
      assign sdig_out[g] = sdig_next[g];
    end else begin : g_zero
      assign sdig_out[g] = 4'd0;
    end
  end

  result_t res_next;
  always_comb begin
    res_next.frame_done      = done;
    res_next.ack_result      = ack;
    res_next.pending         = pend_next;
    res_next.digit_count     = 3'(scnt_next);
    res_next.digits          = sdig_out;
    res_next.frames_received = good_next;
    res_next.errors_seen     = bad_next;
  end

  // handshake and output buffer
  logic    accept, out_fire;
  logic    skid_valid;
  result_t main_res, skid_res;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
      slot  <= '0;
      rxor  <= '0;
      fcnt  <= '0;
      scnt  <= '0;
      good  <= '0;
      bad   <= '0;
      pend  <= 1'b0;
      for (int k = 0; k < DIGIT_SLOTS; k++) begin
        fdig[k] <= '0;
        sdig[k] <= '0;
      end
    end else if (accept) begin
      phase <= phase_next;
      slot  <= slot_next;
      rxor  <= rxor_next;
      fcnt  <= fcnt_next;
      scnt  <= scnt_next;
      good  <= good_next;
      bad   <= bad_next;
      pend  <= pend_next;
      fdig  <= fdig_next;
      sdig  <= sdig_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        main_res   <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid || out_fire) begin
        main_res  <= res_next;
        out_valid <= 1'b1;
      end else begin
        skid_res   <= res_next;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign frame_done      = main_res.frame_done;
  assign ack_result      = main_res.ack_result;
  assign pending         = main_res.pending;
  assign digit_count     = main_res.digit_count;
  assign digit_0         = main_res.digits[0];
  assign digit_1         = main_res.digits[1];
  assign digit_2         = main_res.digits[2];
  assign digit_3         = main_res.digits[3];
  assign frames_received = main_res.frames_received;
  assign errors_seen     = main_res.errors_seen;

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without a result in the output register");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled while output was not stalled");

  a_done_sets_pending: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> pending && !ack_result)
    else $error("published frame without pending flag");

  a_good_count_step: assert property (@(posedge clk) disable iff (rst)
    accept |=> good == $past(good) + CTR_W'($past(done)))
    else $error("good frame counter out of step with frame_done");

  a_ack_clears: assert property (@(posedge clk) disable iff (rst)
    accept && command |=> !pend)
    else $error("acknowledge did not clear pending flag");

endmodule

// ----- tb/digit_frame_receiver_test.sv -----
// Self-checking testbench for digit_frame_receiver: frame parsing, acks, counters, registers.
// Predicts each result with a cycle-free model of the parser and compares every output field.
// Depends on dfr_pkg and the digit_frame_receiver RTL.
`timescale 1ns / 1ps

module digit_frame_receiver_test;
  import dfr_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_ACK  = 1'b1;

  typedef enum logic [2:0] {SEEK_HEAD, GET_COUNT, GET_DIGITS, GET_CHECK, GET_TAIL} parse_phase_e;

  class frame_result_checker;
    logic [7:0]   head_val;
    logic [7:0]   tail_val;
    logic [3:0]   limit_val;
    parse_phase_e phase;
    logic [2:0]   slot;
    logic [7:0]   check_acc;
    logic [2:0]   count_field;
    logic [3:0]   frame_dig[4];
    logic [2:0]   shown_count;
    logic [3:0]   shown_dig[4];
    logic [31:0]  good_cnt;
    logic [31:0]  bad_cnt;
    logic         pend;
    result_t      awaited_results[$];
    int           mismatches;

    function new();
      head_val    = HEAD_BYTE_RST;
      tail_val    = TAIL_BYTE_RST;
      limit_val   = DIGIT_LIMIT_RST;
      phase       = SEEK_HEAD;
      slot        = '0;
      check_acc   = '0;
      count_field = '0;
      shown_count = '0;
      good_cnt    = '0;
      bad_cnt     = '0;
      pend        = 1'b0;
      mismatches  = 0;
      foreach (frame_dig[k]) begin
        frame_dig[k] = '0;
        shown_dig[k] = '0;
      end
    endfunction

    function void set_register(reg_idx_t idx, logic [7:0] val);
      case (idx)
        REG_HEAD_BYTE:   head_val = val;
        REG_TAIL_BYTE:   tail_val = val;
        REG_DIGIT_LIMIT: limit_val = val[3:0];
        default: ;
      endcase
    endfunction

    function void frame_error(logic [7:0] b);
      bad_cnt++;
      phase = (b == head_val) ? GET_COUNT : SEEK_HEAD;
    endfunction

    function void note_item(logic cmd, logic [7:0] b);
      result_t r;
      logic    done;
      logic    ack;
      logic    used;
      logic    ok;
      done = 1'b0;
      ack  = 1'b0;
      if (cmd == CMD_ACK) begin
        ack  = pend;
        pend = 1'b0;
      end else begin
        case (phase)
          SEEK_HEAD: if (b == head_val && !pend) phase = GET_COUNT;
          GET_COUNT: begin
            if (b <= DIGIT_SLOTS_DEF) begin
              count_field = b[2:0];
              check_acc   = b;
              slot        = '0;
              phase       = GET_DIGITS;
            end else begin
              frame_error(b);
            end
          end
          GET_DIGITS: begin
            used = slot < count_field;
            ok   = used ? (b >= 1 && b <= limit_val) : (b == 0);
            if (ok) begin
              frame_dig[slot] = b[3:0];
              slot++;
              check_acc ^= b;
              if (slot >= DIGIT_SLOTS_DEF) phase = GET_CHECK;
            end else begin
              frame_error(b);
            end
          end
          GET_CHECK: begin
            if (b == check_acc) phase = GET_TAIL;
            else frame_error(b);
          end
          GET_TAIL: begin
            if (b == tail_val) begin
              shown_count = count_field;
              for (int i = 0; i < count_field; i++) shown_dig[i] = frame_dig[i];
              good_cnt++;
              pend  = 1'b1;
              phase = SEEK_HEAD;
              done  = 1'b1;
            end else begin
              frame_error(b);
            end
          end
          default: phase = SEEK_HEAD;
        endcase
      end
      r.frame_done      = done;
      r.ack_result      = ack;
      r.pending         = pend;
      r.digit_count     = shown_count;
      for (int k = 0; k < OUT_DIGITS; k++) r.digits[k] = shown_dig[k];
      r.frames_received = good_cnt;
      r.errors_seen     = bad_cnt;
      awaited_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_item(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected, expected none actual %h", $time, got);
        return;
      end
      want = awaited_results.pop_front();
      compare_field("frame_done", 32'(want.frame_done), 32'(got.frame_done));
      compare_field("ack_result", 32'(want.ack_result), 32'(got.ack_result));
      compare_field("pending", 32'(want.pending), 32'(got.pending));
      compare_field("digit_count", 32'(want.digit_count), 32'(got.digit_count));
      for (int k = 0; k < OUT_DIGITS; k++)
        compare_field($sformatf("digit_%0d", k), 32'(want.digits[k]), 32'(got.digits[k]));
      compare_field("frames_received", want.frames_received, got.frames_received);
      compare_field("errors_seen", want.errors_seen, got.errors_seen);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                command = CMD_BYTE;
  logic [7:0]          rx_byte = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic                frame_done;
  logic                ack_result;
  logic                pending;
  logic [2:0]          digit_count;
  logic [3:0]          digit_0;
  logic [3:0]          digit_1;
  logic [3:0]          digit_2;
  logic [3:0]          digit_3;
  logic [CTR_W-1:0]    frames_received;
  logic [CTR_W-1:0]    errors_seen;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  frame_result_checker sb = new();
  int                  items_sent = 0;
  int                  cycles = 0;
  int                  src_gap_max = 0;
  int                  snk_gap_max = 0;
  bit                  hold_request = 1'b0;

  digit_frame_receiver DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .command(command), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .frame_done(frame_done), .ack_result(ack_result), .pending(pending),
    .digit_count(digit_count),
    .digit_0(digit_0), .digit_1(digit_1), .digit_2(digit_2), .digit_3(digit_3),
    .frames_received(frames_received), .errors_seen(errors_seen),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("digit_frame_receiver: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen.frame_done      = frame_done;
      seen.ack_result      = ack_result;
      seen.pending         = pending;
      seen.digit_count     = digit_count;
      seen.digits          = {digit_3, digit_2, digit_1, digit_0};
      seen.frames_received = frames_received;
      seen.errors_seen     = errors_seen;
      sb.check_item(seen);
    end
  end

  // result side: random stall per item, plus one long hold-off on request
  initial begin
    int hold;
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        hold = 0;
      end else begin
        hold = (snk_gap_max == 0) ? 0 : $urandom_range(0, snk_gap_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_item(logic cmd, logic [7:0] b);
    int gap;
    gap = (src_gap_max == 0) ? 0 : $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    sb.note_item(cmd, b);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_register(idx, val);
  endtask

  // bad_pos 0 sends a clean frame; 1..7 corrupts that byte position
  task automatic send_frame(int cnt, int bad_pos, bit at_limit);
    logic [7:0] fb[8];
    logic [7:0] acc;
    int         lim;
    int         i;
    lim   = int'(sb.limit_val);
    fb[0] = sb.head_val;
    fb[1] = cnt[7:0];
    acc   = cnt[7:0];
    for (i = 0; i < 4; i++) begin
      if (i < cnt) fb[2+i] = at_limit ? ((i % 2 == 0) ? 8'd1 : 8'(lim)) : 8'($urandom_range(1, lim));
      else fb[2+i] = 8'd0;
      acc ^= fb[2+i];
    end
    fb[6] = acc;
    fb[7] = sb.tail_val;
    if (bad_pos == 1) begin
      fb[1] = 8'($urandom_range(5, 255));
    end else if (bad_pos >= 2 && bad_pos <= 5) begin
      i = bad_pos - 2;
      if (i < cnt) fb[bad_pos] = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(lim + 1, 255));
      else fb[bad_pos] = 8'($urandom_range(1, 255));
    end else if (bad_pos >= 6) begin
      fb[bad_pos] ^= 8'($urandom_range(1, 255));
    end
    if (bad_pos > 0 && $urandom_range(0, 3) == 0) fb[bad_pos] = sb.head_val;
    for (i = 0; i < 8; i++) send_item(CMD_BYTE, fb[i]);
  endtask

  task automatic run_random(int budget);
    int target;
    int pick;
    target = items_sent + budget;
    while (items_sent < target) begin
      src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      snk_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame((sb.limit_val == 0) ? 0 : $urandom_range(0, 4), 0, 1'b0);
        if ($urandom_range(0, 4) != 0) send_item(CMD_ACK, 8'($urandom));
      end else if (pick < 75) begin
        send_frame($urandom_range(0, 4), $urandom_range(1, 7), 1'b0);
      end else if (pick < 87) begin
        repeat ($urandom_range(1, 4))
          send_item(CMD_BYTE, ($urandom_range(0, 2) == 0) ? sb.head_val : 8'($urandom));
      end else begin
        send_item(CMD_ACK, 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings, back-to-back
    send_frame(4, 0, 1'b1);
    send_item(CMD_BYTE, HEAD_BYTE_RST);   // ignored, result still pending
    send_item(CMD_ACK, 8'hFF);
    send_item(CMD_ACK, 8'h00);            // nothing pending
    send_frame(0, 0, 1'b0);
    send_item(CMD_ACK, 8'h00);
    send_item(CMD_BYTE, HEAD_BYTE_RST);
    send_item(CMD_BYTE, 8'hFF);           // bad count
    send_item(CMD_BYTE, HEAD_BYTE_RST);
    send_item(CMD_BYTE, HEAD_BYTE_RST);   // bad count equal to head restarts
    send_item(CMD_BYTE, 8'd5);
    run_random(60);

    drain();
    write_reg(REG_HEAD_BYTE, 8'hFF);
    write_reg(REG_TAIL_BYTE, 8'h00);
    write_reg(REG_DIGIT_LIMIT, 8'd15);
    src_gap_max = 0;
    send_frame(4, 0, 1'b1);
    send_item(CMD_ACK, 8'h5A);
    run_random(60);

    drain();
    write_reg(REG_HEAD_BYTE, 8'h00);
    write_reg(REG_TAIL_BYTE, 8'hFF);
    write_reg(REG_DIGIT_LIMIT, 8'd1);
    run_random(60);
    drain();                              // sender waits for all results
    run_random(20);

    // head that is also a legal count; no nonzero digit allowed
    drain();
    write_reg(REG_HEAD_BYTE, 8'd3);
    write_reg(REG_TAIL_BYTE, TAIL_BYTE_RST);
    write_reg(REG_DIGIT_LIMIT, 8'd0);
    src_gap_max = 0;
    send_frame(0, 0, 1'b0);
    send_item(CMD_ACK, 8'h00);
    send_frame(1, 0, 1'b0);
    run_random(60);

    drain();
    write_reg(REG_HEAD_BYTE, 8'($urandom));
    write_reg(REG_TAIL_BYTE, 8'($urandom));
    write_reg(REG_DIGIT_LIMIT, 8'($urandom_range(1, 15)));
    src_gap_max  = 0;
    hold_request = 1'b1;
    repeat (6) begin
      send_frame($urandom_range(0, 4), 0, 1'b0);
      send_item(CMD_ACK, 8'($urandom));
    end
    run_random(60);

    drain();
    if (sb.mismatches == 0 && sb.awaited_results.size() == 0) begin
      $display("digit_frame_receiver: match");
    end else begin
      $display("digit_frame_receiver: mismatch");
    end
    $finish;
  end

endmodule
